FILE: sv/rotational_kinetic_energy_sum_unit_assert.svh
// assertion macros for the rotational kinetic energy sum unit
`ifndef ROTATIONAL_KINETIC_ENERGY_SUM_UNIT_ASSERT_SVH
`define ROTATIONAL_KINETIC_ENERGY_SUM_UNIT_ASSERT_SVH

// condition now implies consequence now
`define RKES_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rkes assertion failed");

// condition now implies consequence in the next cycle
`define RKES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rkes assertion failed");

`endif

FILE: sv/rkes_pkg.sv
`timescale 1ns / 1ps
package rkes_pkg;

  localparam int QW    = 32;   // quaternion component width
  localparam int PW    = 33;   // negated momentum scalar needs one more bit
  localparam int VW    = 36;   // vector part accumulator
  localparam int MAGW  = 35;   // magnitude of a vector component
  localparam int FW    = 20;   // packed inertia field
  localparam int MW    = 37;   // shared multiplier operand, signed
  localparam int PRW   = 2 * MW;
  localparam int WW    = 54;   // w = |v| * inv_inertia
  localparam int HW    = WW / 2;
  localparam int SQW   = 2 * WW;
  localparam int CW    = SQW / 3;
  localparam int CPW   = CW + FW;
  localparam int IPW   = 128;
  localparam int EW    = 64;
  localparam int FRAC_SHIFT = 30;
  localparam int E_SHIFT    = 43;
  localparam int HAM_N = 12;
  localparam int AXES  = 3;

  typedef struct packed {
    logic signed [QW-1:0] mom_r;
    logic signed [QW-1:0] mom_i;
    logic signed [QW-1:0] mom_j;
    logic signed [QW-1:0] mom_k;
    logic signed [QW-1:0] ori_r;
    logic signed [QW-1:0] ori_i;
    logic signed [QW-1:0] ori_j;
    logic signed [QW-1:0] ori_k;
    logic [3*FW-1:0]      inertia_packed;
    logic [3*FW-1:0]      inv_inertia_packed;
    logic                 last_body;
  } in_beat_t;

  typedef struct packed {
    logic [EW-1:0] energy_total;
    logic          is_final;
  } out_beat_t;

  // hamilton product schedule, four terms per vector component
  localparam logic [1:0] HAM_P [HAM_N] = '{
    2'd0, 2'd1, 2'd2, 2'd3,  2'd0, 2'd1, 2'd2, 2'd3,  2'd0, 2'd1, 2'd2, 2'd3};
  localparam logic [1:0] HAM_Q [HAM_N] = '{
    2'd1, 2'd0, 2'd3, 2'd2,  2'd2, 2'd3, 2'd0, 2'd1,  2'd3, 2'd2, 2'd1, 2'd0};
  localparam logic HAM_NEG [HAM_N] = '{
    1'b0, 1'b0, 1'b0, 1'b1,  1'b0, 1'b1, 1'b0, 1'b0,  1'b0, 1'b0, 1'b1, 1'b0};

  function automatic logic [EW-1:0] sat_add(input logic [EW-1:0] a, input logic [EW-1:0] b);
    logic [EW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[EW] ? {EW{1'b1}} : s[EW-1:0];
  endfunction

  function automatic logic [EW-1:0] axis_energy(input logic [IPW-1:0] ip);
    return (ip[IPW-1:E_SHIFT+EW] != '0) ? {EW{1'b1}} : ip[E_SHIFT+EW-1:E_SHIFT];
  endfunction

endpackage

FILE: sv/rkes_chan_if.sv
`timescale 1ns / 1ps
interface rkes_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/rotational_kinetic_energy_sum_unit.sv
`timescale 1ns / 1ps
// flow: a body beat is accepted only while idle, so one body is worked at a time; its
//   result is registered once the output is free or being taken; all
//   33 multiplications of a body go one by one through a single 37x37 multiplier,
//   each product registered and then accumulated, plus one fold step per axis
// reset: rst_n synchronous active low; clears the running total, the sequencer
//   and the output valid; a result waiting at the output does not stop the next accept
module rotational_kinetic_energy_sum_unit (
  input  logic         clk,
  input  logic         rst_n,
  rkes_chan_if.sink    in_beat,
  rkes_chan_if.source  out_beat
);
  import rkes_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_HAM, S_AXIS, S_ACC} state_t;

  state_t                 state_r;
  logic                   half_r;
  logic [3:0]             hcnt_r;
  logic [1:0]             axis_r;
  logic [2:0]             sub_r;
  logic signed [PW-1:0]   p_r [4];
  logic signed [QW-1:0]   q_r [4];
  logic [3*FW-1:0]        inert_r;
  logic [3*FW-1:0]        inv_r;
  logic                   last_r;
  logic signed [VW-1:0]   v_r [AXES];
  logic [WW-1:0]          w_r;
  logic [SQW-1:0]         sq_r;
  logic [IPW-1:0]         ip_r;
  logic [EW-1:0]          term_r;
  logic [EW-1:0]          acc_r;
  logic signed [PRW-1:0]  prod_r;
  out_beat_t              out_r;
  logic                   out_valid_r;

  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [PRW-1:0]  prod_nxt;
  logic signed [PW-1:0]   p_sel;
  logic signed [QW-1:0]   q_sel;
  logic signed [VW-1:0]   v_sel;
  logic signed [VW-1:0]   v_neg;
  logic [MAGW-1:0]        vmag;
  logic [FW-1:0]          inert_a;
  logic [FW-1:0]          inv_a;
  logic signed [VW-1:0]   fl;
  logic [EW-1:0]          sum_nxt;

  assign p_sel = p_r[HAM_P[hcnt_r]];
  assign q_sel = q_r[HAM_Q[hcnt_r]];
  assign v_sel = v_r[axis_r];
  assign v_neg = -v_sel;
  assign vmag  = v_sel[VW-1] ? v_neg[MAGW-1:0] : v_sel[MAGW-1:0];
  // floor of product / 2^30
  assign fl    = $signed(prod_r[FRAC_SHIFT+VW-1:FRAC_SHIFT]);
  assign sum_nxt = sat_add(acc_r, term_r);

  always_comb begin
    unique case (axis_r)
      2'd0:    begin inert_a = inert_r[FW-1:0];      inv_a = inv_r[FW-1:0];      end
      2'd1:    begin inert_a = inert_r[2*FW-1:FW];   inv_a = inv_r[2*FW-1:FW];   end
      default: begin inert_a = inert_r[3*FW-1:2*FW]; inv_a = inv_r[3*FW-1:2*FW]; end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_HAM: begin
        mul_a = MW'(p_sel);
        mul_b = MW'(q_sel);
      end
      S_AXIS: begin
        unique case (sub_r)
          3'd0: begin mul_a = MW'(vmag);             mul_b = MW'(inv_a);        end
          3'd1: begin mul_a = MW'(w_r[HW-1:0]);      mul_b = MW'(w_r[HW-1:0]);  end
          3'd2: begin mul_a = MW'(w_r[WW-1:HW]);     mul_b = MW'(w_r[HW-1:0]);  end
          3'd3: begin mul_a = MW'(w_r[WW-1:HW]);     mul_b = MW'(w_r[WW-1:HW]); end
          3'd4: begin mul_a = MW'(sq_r[CW-1:0]);     mul_b = MW'(inert_a);      end
          3'd5: begin mul_a = MW'(sq_r[2*CW-1:CW]);  mul_b = MW'(inert_a);      end
          3'd6: begin mul_a = MW'(sq_r[3*CW-1:2*CW]); mul_b = MW'(inert_a);     end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      half_r      <= 1'b0;
      hcnt_r      <= '0;
      axis_r      <= '0;
      sub_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_beat.ready && (state_r != S_ACC)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_beat.valid) begin
            p_r[0]  <= -PW'(in_beat.data.mom_r);
            p_r[1]  <= PW'(in_beat.data.mom_i);
            p_r[2]  <= PW'(in_beat.data.mom_j);
            p_r[3]  <= PW'(in_beat.data.mom_k);
            q_r[0]  <= in_beat.data.ori_r;
            q_r[1]  <= in_beat.data.ori_i;
            q_r[2]  <= in_beat.data.ori_j;
            q_r[3]  <= in_beat.data.ori_k;
            inert_r <= in_beat.data.inertia_packed;
            inv_r   <= in_beat.data.inv_inertia_packed;
            last_r  <= in_beat.data.last_body;
            for (int i = 0; i < AXES; i++) v_r[i] <= '0;
            term_r  <= '0;
            hcnt_r  <= '0;
            half_r  <= 1'b0;
            state_r <= S_HAM;
          end
        end
        S_HAM: begin
          if (!half_r) begin
            prod_r <= prod_nxt;
            half_r <= 1'b1;
          end else begin
            v_r[hcnt_r[3:2]] <= HAM_NEG[hcnt_r] ? v_r[hcnt_r[3:2]] - fl
                                                : v_r[hcnt_r[3:2]] + fl;
            half_r <= 1'b0;
            if (hcnt_r == 4'(HAM_N - 1)) begin
              axis_r  <= '0;
              sub_r   <= '0;
              state_r <= S_AXIS;
            end else begin
              hcnt_r <= hcnt_r + 4'd1;
            end
          end
        end
        S_AXIS: begin
          if (sub_r == 3'd7) begin
            term_r <= sat_add(term_r, axis_energy(ip_r));
            sub_r  <= '0;
            if (axis_r == 2'(AXES - 1)) state_r <= S_ACC;
            else                        axis_r  <= axis_r + 2'd1;
          end else if (!half_r) begin
            prod_r <= prod_nxt;
            half_r <= 1'b1;
          end else begin
            unique case (sub_r)
              3'd0: w_r  <= prod_r[WW-1:0];
              3'd1: sq_r <= SQW'(prod_r[WW-1:0]);
              3'd2: sq_r <= sq_r + (SQW'(prod_r[WW-1:0]) << (HW + 1));
              3'd3: sq_r <= sq_r + (SQW'(prod_r[WW-1:0]) << WW);
              3'd4: ip_r <= IPW'(prod_r[CPW-1:0]);
              3'd5: ip_r <= ip_r + (IPW'(prod_r[CPW-1:0]) << CW);
              3'd6: ip_r <= ip_r + (IPW'(prod_r[CPW-1:0]) << (2 * CW));
              default: ip_r <= ip_r;
            endcase
            sub_r  <= sub_r + 3'd1;
            half_r <= 1'b0;
          end
        end
        S_ACC: begin
          if (!out_valid_r || out_beat.ready) begin
            out_r.energy_total <= sum_nxt;
            out_r.is_final     <= last_r;
            out_valid_r        <= 1'b1;
            acc_r              <= last_r ? '0 : sum_nxt;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_beat.ready  = (state_r == S_IDLE);
  assign out_beat.valid = out_valid_r;
  assign out_beat.data  = out_r;

endmodule

FILE: sv/rkes_checker.sv
`timescale 1ns / 1ps
`include "rotational_kinetic_energy_sum_unit_assert.svh"
module rkes_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rkes_pkg::out_beat_t out_data
);
  import rkes_pkg::*;

  logic in_fire;
  logic out_stall;

  assign in_fire   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  `RKES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)
  `RKES_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(out_data))
  // the sequencer owns the multiplier after a body beat is accepted, so the input is not ready
  `RKES_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready)
  `RKES_ASSERT_NOW(a_busy_two, clk, rst_n, $past(in_fire, 2) && $past(rst_n, 2) && $past(rst_n), !in_ready)

endmodule

bind rotational_kinetic_energy_sum_unit rkes_checker u_rkes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_beat.valid),
  .in_ready  (in_beat.ready),
  .out_valid (out_beat.valid),
  .out_ready (out_beat.ready),
  .out_data  (out_beat.data)
);
